// ===== rtl/core/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler converter
// Fixed-point widths, the CORDIC arctangent table and angle constants in Q30.
// ----------------------------------------------------------------------------
`default_nettype none
package qte_pkg;

   // Internal Q1.15 quaternion component width
   localparam int Q_WIDTH    = 16;
   // Product of two Q1.15 values
   localparam int PROD_WIDTH = 32;
   // Sum-of-products terms in Q5.30, with headroom for any input pattern
   localparam int SUM_WIDTH  = 35;
   // CORDIC x/y datapath width
   localparam int XY_WIDTH   = 37;
   // CORDIC angle accumulator width, units of 2^-30 rad
   localparam int ACC_WIDTH  = 34;
   // Square-root datapath
   localparam int SQ_WIDTH   = 62;
   localparam int RAD_WIDTH  = 61;
   localparam int ROOT_WIDTH = 31;
   localparam int ROOT_STEPS = 31;
   // Pitch operand width when not saturated
   localparam int SP_WIDTH   = 31;

   localparam logic signed [ACC_WIDTH-1:0] PIHALF_Q30 = 34'sd1686629713;
   localparam longint PI_Q30_L     = 64'sd3373259426;
   localparam longint PIHALF_Q30_L = 64'sd1686629713;

   // atan(2^-i) * 2^30, rounded down
   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
      32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
      32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
      32'd262143,    32'd131071,    32'd65535,     32'd32767,
      32'd16383,     32'd8191,      32'd4095,      32'd2047,
      32'd1023,      32'd511,       32'd255,       32'd127,
      32'd63,        32'd31,        32'd15,        32'd7,
      32'd3,         32'd1,         32'd0,         32'd0
   };

   // Operands carried alongside the square-root pipeline
   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] sr;
      logic signed [SUM_WIDTH-1:0] cr;
      logic signed [SUM_WIDTH-1:0] sy;
      logic signed [SUM_WIDTH-1:0] cy;
      logic signed [SP_WIDTH-1:0]  sp;
      logic                        sat;
      logic                        neg;
   } side_type;

endpackage
`default_nettype wire

// ===== rtl/core/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// Floor square root of a 61-bit radicand, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_isqrt
   import qte_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [RAD_WIDTH-1:0]  radicand,
   output logic      [ROOT_WIDTH-1:0] root
);

   logic [SQ_WIDTH-1:0] rem_ff  [1:ROOT_STEPS];
   logic [SQ_WIDTH-1:0] root_ff [1:ROOT_STEPS];

   // One restoring step per stage, trial bit falling by four each time
   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
      localparam logic [SQ_WIDTH-1:0] BIT = SQ_WIDTH'(1) << (2 * (ROOT_STEPS - 1 - j));
      logic [SQ_WIDTH-1:0] rem_cur;
      logic [SQ_WIDTH-1:0] root_cur;
      logic [SQ_WIDTH-1:0] trial;
      // Stage zero works on the input itself
      if (j == 0) begin : g_first
         assign rem_cur  = {1'b0, radicand};
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[j];
         assign root_cur = root_ff[j];
      end
      assign trial = root_cur + BIT;
      always_ff @(posedge clock) begin
         if (rem_cur >= trial) begin
            rem_ff[j+1]  <= rem_cur - trial;
            root_ff[j+1] <= (root_cur >> 1) + BIT;
         end else begin
            rem_ff[j+1]  <= rem_cur;
            root_ff[j+1] <= root_cur >> 1;
         end
      end
   end

   assign root = root_ff[ROOT_STEPS][ROOT_WIDTH-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC arctangent
// Four-quadrant atan2(y, x) in units of 2^-30 rad, one micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_cordic
   import qte_pkg::*;
#(
   parameter int STAGES = 16
) (
   input  wire logic                        clock,
   input  wire logic signed [XY_WIDTH-1:0]  y_in,
   input  wire logic signed [XY_WIDTH-1:0]  x_in,
   output logic      signed [ACC_WIDTH-1:0] angle
);

   logic signed [XY_WIDTH-1:0]  x_ff    [0:STAGES];
   logic signed [XY_WIDTH-1:0]  y_ff    [0:STAGES];
   logic signed [ACC_WIDTH-1:0] ang_ff  [0:STAGES];
   logic                        zero_ff [0:STAGES];

   // Rotate left half-plane into the right half-plane
   always_ff @(posedge clock) begin
      zero_ff[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
         if (y_in >= 0) begin
            x_ff[0]   <= y_in;
            y_ff[0]   <= -x_in;
            ang_ff[0] <= PIHALF_Q30;
         end else begin
            x_ff[0]   <= -y_in;
            y_ff[0]   <= x_in;
            ang_ff[0] <= -PIHALF_Q30;
         end
      end else begin
         x_ff[0]   <= x_in;
         y_ff[0]   <= y_in;
         ang_ff[0] <= '0;
      end
   end

   // Drive y toward zero, one shift-add per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [ACC_WIDTH-1:0] step;
      logic signed [XY_WIDTH-1:0]  xs;
      logic signed [XY_WIDTH-1:0]  ys;
      assign step = $signed({{(ACC_WIDTH-32){1'b0}}, ATAN_TAB[i]});
      assign xs   = x_ff[i] >>> i;
      assign ys   = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1]   <= x_ff[i] + ys;
            y_ff[i+1]   <= y_ff[i] - xs;
            ang_ff[i+1] <= ang_ff[i] + step;
         end else begin
            x_ff[i+1]   <= x_ff[i] - ys;
            y_ff[i+1]   <= y_ff[i] + xs;
            ang_ff[i+1] <= ang_ff[i] - step;
         end
      end
   end

   // Both operands zero gives angle zero
   assign angle = zero_ff[STAGES] ? '0 : ang_ff[STAGES];

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: Z-Y-X Euler angles from a unit quaternion
// Roll, pitch and yaw through a fully pipelined product, square-root and
// CORDIC datapath.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle and busy is high only during
// reset. Each transaction passes CORDIC_STAGES + 38 register stages: five of
// products and sums, one per result bit of the 31-stage pitch square root,
// CORDIC_STAGES + 1 of arctangent and one of rounding, before its result is
// shown on rsp_strobe. The receiver cannot stall the pipeline; results must
// be taken when strobed.
`default_nettype none
module quaternion_to_euler_angles
   import qte_pkg::*;
#(
   parameter int QUAT_WIDTH    = 16,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [QUAT_WIDTH-1:0]  req_quat_w,
   input  wire logic signed [QUAT_WIDTH-1:0]  req_quat_x,
   input  wire logic signed [QUAT_WIDTH-1:0]  req_quat_y,
   input  wire logic signed [QUAT_WIDTH-1:0]  req_quat_z,
   output logic                               rsp_strobe,
   output logic signed [ANGLE_WIDTH-1:0]      rsp_roll_angle,
   output logic signed [ANGLE_WIDTH-2:0]      rsp_pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0]      rsp_yaw_angle,
   output logic                               rsp_pitch_saturated
);

   localparam int SH      = 33 - ANGLE_WIDTH;
   localparam int RW      = ACC_WIDTH + 1;
   localparam int LATENCY = CORDIC_STAGES + 38;
   localparam int CLAT    = CORDIC_STAGES + 1;
   localparam longint PI_LIM_L   = (PI_Q30_L + (64'sd1 <<< (SH - 1))) >>> SH;
   localparam longint HALF_LIM_L = (PIHALF_Q30_L + (64'sd1 <<< (SH - 1))) >>> SH;
   localparam logic signed [RW-1:0] PI_LIM   = RW'(PI_LIM_L);
   localparam logic signed [RW-1:0] HALF_LIM = RW'(HALF_LIM_L);
   localparam logic signed [RW-1:0] HALF_RND = RW'(64'sd1 <<< (SH - 1));
   localparam logic signed [SUM_WIDTH-1:0] ONE_Q30 = SUM_WIDTH'(64'sd1 <<< 30);

   // Valid line that follows each transaction down the pipe
   logic valid_ff [0:LATENCY-1];

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LATENCY; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= start;
         for (int k = 1; k < LATENCY; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // Bring the components to Q1.15
   logic signed [Q_WIDTH-1:0] qw, qx, qy, qz;
   if (QUAT_WIDTH >= Q_WIDTH) begin : g_down
      assign qw = req_quat_w[QUAT_WIDTH-1 -: Q_WIDTH];
      assign qx = req_quat_x[QUAT_WIDTH-1 -: Q_WIDTH];
      assign qy = req_quat_y[QUAT_WIDTH-1 -: Q_WIDTH];
      assign qz = req_quat_z[QUAT_WIDTH-1 -: Q_WIDTH];
   end else begin : g_up
      assign qw = {req_quat_w, {(Q_WIDTH-QUAT_WIDTH){1'b0}}};
      assign qx = {req_quat_x, {(Q_WIDTH-QUAT_WIDTH){1'b0}}};
      assign qy = {req_quat_y, {(Q_WIDTH-QUAT_WIDTH){1'b0}}};
      assign qz = {req_quat_z, {(Q_WIDTH-QUAT_WIDTH){1'b0}}};
   end

   // Stage A: capture the operands
   logic signed [Q_WIDTH-1:0] w_a_ff, x_a_ff, y_a_ff, z_a_ff;
   always_ff @(posedge clock) begin
      w_a_ff <= qw;
      x_a_ff <= qx;
      y_a_ff <= qy;
      z_a_ff <= qz;
   end

   // Stage B: the nine products
   logic signed [PROD_WIDTH-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   always_ff @(posedge clock) begin
      wx_ff <= w_a_ff * x_a_ff;
      yz_ff <= y_a_ff * z_a_ff;
      xx_ff <= x_a_ff * x_a_ff;
      yy_ff <= y_a_ff * y_a_ff;
      wy_ff <= w_a_ff * y_a_ff;
      zx_ff <= z_a_ff * x_a_ff;
      wz_ff <= w_a_ff * z_a_ff;
      xy_ff <= x_a_ff * y_a_ff;
      zz_ff <= z_a_ff * z_a_ff;
   end

   // Stage C: sum-of-products terms in Q5.30
   logic signed [SUM_WIDTH-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   always_ff @(posedge clock) begin
      sr_ff <= (SUM_WIDTH'(wx_ff) + SUM_WIDTH'(yz_ff)) <<< 1;
      cr_ff <= ONE_Q30 - ((SUM_WIDTH'(xx_ff) + SUM_WIDTH'(yy_ff)) <<< 1);
      sp_ff <= (SUM_WIDTH'(wy_ff) - SUM_WIDTH'(zx_ff)) <<< 1;
      sy_ff <= (SUM_WIDTH'(wz_ff) + SUM_WIDTH'(xy_ff)) <<< 1;
      cy_ff <= ONE_Q30 - ((SUM_WIDTH'(yy_ff) + SUM_WIDTH'(zz_ff)) <<< 1);
   end

   // Stage D: detect the pitch clamp and square the sine
   logic signed [SP_WIDTH-1:0] spn;
   logic signed [SQ_WIDTH-1:0] sq_in;
   side_type                   side_d_ff;
   logic        [SQ_WIDTH-1:0] sq_ff;
   assign spn   = sp_ff[SP_WIDTH-1:0];
   assign sq_in = spn * spn;
   always_ff @(posedge clock) begin
      sq_ff         <= sq_in;
      side_d_ff.sr  <= sr_ff;
      side_d_ff.cr  <= cr_ff;
      side_d_ff.sy  <= sy_ff;
      side_d_ff.cy  <= cy_ff;
      side_d_ff.sp  <= spn;
      side_d_ff.sat <= (sp_ff >= ONE_Q30) || (sp_ff <= -ONE_Q30);
      side_d_ff.neg <= sp_ff[SUM_WIDTH-1];
   end

   // Stage E: radicand for the cosine of pitch
   logic [SQ_WIDTH-1:0]  rad_full;
   logic [RAD_WIDTH-1:0] rad_ff;
   side_type             side_e_ff;
   assign rad_full = (SQ_WIDTH'(1) << 60) - sq_ff;
   always_ff @(posedge clock) begin
      rad_ff    <= rad_full[RAD_WIDTH-1:0];
      side_e_ff <= side_d_ff;
   end

   // Square root, with the other operands held alongside
   logic [ROOT_WIDTH-1:0] root;
   side_type              side_ff [0:ROOT_STEPS-1];

   qte_isqrt u_isqrt (
      .clock    (clock),
      .radicand (rad_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      side_ff[0] <= side_e_ff;
      for (int k = 1; k < ROOT_STEPS; k++) side_ff[k] <= side_ff[k-1];
   end

   // Three arctangents in parallel
   side_type                    side_s;
   logic signed [ACC_WIDTH-1:0] roll_acc, pitch_acc, yaw_acc;
   assign side_s = side_ff[ROOT_STEPS-1];

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock (clock),
      .y_in  (XY_WIDTH'(side_s.sr)),
      .x_in  (XY_WIDTH'(side_s.cr)),
      .angle (roll_acc)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock (clock),
      .y_in  (XY_WIDTH'(side_s.sp)),
      .x_in  ($signed({{(XY_WIDTH-ROOT_WIDTH){1'b0}}, root})),
      .angle (pitch_acc)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock (clock),
      .y_in  (XY_WIDTH'(side_s.sy)),
      .x_in  (XY_WIDTH'(side_s.cy)),
      .angle (yaw_acc)
   );

   // Hold the clamp flag and the pitch sign until the angles emerge
   logic sat_ff [0:CLAT-1];
   logic neg_ff [0:CLAT-1];
   always_ff @(posedge clock) begin
      sat_ff[0] <= side_s.sat;
      neg_ff[0] <= side_s.neg;
      for (int k = 1; k < CLAT; k++) begin
         sat_ff[k] <= sat_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   // Round to output units, half up, and clamp
   logic signed [RW-1:0] roll_r, pitch_r, yaw_r;
   logic signed [RW-1:0] roll_c, pitch_c, yaw_c;
   always_comb begin
      roll_r  = (RW'(roll_acc)  + HALF_RND) >>> SH;
      pitch_r = (RW'(pitch_acc) + HALF_RND) >>> SH;
      yaw_r   = (RW'(yaw_acc)   + HALF_RND) >>> SH;
      roll_c  = (roll_r > PI_LIM) ? PI_LIM : ((roll_r < -PI_LIM) ? -PI_LIM : roll_r);
      yaw_c   = (yaw_r > PI_LIM) ? PI_LIM : ((yaw_r < -PI_LIM) ? -PI_LIM : yaw_r);
      if (sat_ff[CLAT-1]) begin
         pitch_c = neg_ff[CLAT-1] ? -HALF_LIM : HALF_LIM;
      end else begin
         pitch_c = (pitch_r > HALF_LIM) ? HALF_LIM :
                   ((pitch_r < -HALF_LIM) ? -HALF_LIM : pitch_r);
      end
   end

   // Output register
   logic signed [ANGLE_WIDTH-1:0] roll_ff, yaw_ff;
   logic signed [ANGLE_WIDTH-2:0] pitch_ff;
   logic                          psat_ff;
   always_ff @(posedge clock) begin
      roll_ff  <= roll_c[ANGLE_WIDTH-1:0];
      pitch_ff <= pitch_c[ANGLE_WIDTH-2:0];
      yaw_ff   <= yaw_c[ANGLE_WIDTH-1:0];
      psat_ff  <= sat_ff[CLAT-1];
   end

   assign rsp_strobe          = valid_ff[LATENCY-1];
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_pitch_saturated = psat_ff;

endmodule
`default_nettype wire

// ===== dv/quaternion_to_euler_angles_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb: self-checking bench for the Euler converter
// Drives quaternions through the start/busy command port. Computes each
// expected roll, pitch, yaw and clamp flag with a local fixed-point CORDIC
// model, and compares every strobed result in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
   import qte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QW = 16;
   localparam int AW = 16;
   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 38;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint ONE_Q30 = 64'sd1 << 30;

   typedef struct {
      logic signed [AW-1:0] roll;
      logic signed [AW-2:0] pitch;
      logic signed [AW-1:0] yaw;
      logic                 sat;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [QW-1:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_strobe;
   logic signed [AW-1:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [AW-2:0] rsp_pitch_angle;
   logic rsp_pitch_saturated;

   angles_type expected_angles[$];
   int error_count = 0;
   int idle_cycles = 0;
   int send_gap_pct = 0;

   quaternion_to_euler_angles #(
      .QUAT_WIDTH(QW), .ANGLE_WIDTH(AW), .CORDIC_STAGES(STAGES)
   ) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_strobe(rsp_strobe), .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_pitch_saturated(rsp_pitch_saturated)
   );

   always #6 clock = ~clock;

   // floor shift of a signed value
   function automatic longint shr_floor(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // vectoring CORDIC, angle in 2^-30 rad
   function automatic longint vector_angle(longint y, longint x);
      longint ang, t, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; ang = PIHALF_Q30_L;
         end else begin
            t = x; x = -y; y = t; ang = -PIHALF_Q30_L;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; ang += longint'(ATAN_TAB[i]);
         end else begin
            x -= ys; y += xs; ang -= longint'(ATAN_TAB[i]);
         end
      end
      return ang;
   endfunction

   function automatic longint round_angle(longint q30);
      int sh;
      sh = 33 - AW;
      return shr_floor(q30 + (64'sd1 << (sh - 1)), sh);
   endfunction

   function automatic longint limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic angles_type euler_of(longint w, longint x, longint y, longint z);
      angles_type a;
      longint sr, cr, sp, sy, cy, pi_lim, half_lim, c;
      pi_lim = round_angle(PI_Q30_L);
      half_lim = round_angle(PIHALF_Q30_L);
      sr = 2 * (w * x + y * z);
      cr = ONE_Q30 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = ONE_Q30 - 2 * (y * y + z * z);
      a.roll = AW'(limit(round_angle(vector_angle(sr, cr)), pi_lim));
      a.yaw = AW'(limit(round_angle(vector_angle(sy, cy)), pi_lim));
      if (sp >= ONE_Q30) begin
         a.pitch = (AW-1)'(half_lim); a.sat = 1'b1;
      end else if (sp <= -ONE_Q30) begin
         a.pitch = (AW-1)'(-half_lim); a.sat = 1'b1;
      end else begin
         c = root_floor((64'sd1 << 60) - sp * sp);
         a.pitch = (AW-1)'(limit(round_angle(vector_angle(sp, c)), half_lim));
         a.sat = 1'b0;
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // send one transaction, holding off per the current gap rate
   task automatic send_quat(int w, int x, int y, int z);
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_quat_w <= QW'(w); req_quat_x <= QW'(x); req_quat_y <= QW'(y); req_quat_z <= QW'(z);
      do @(posedge clock); while (busy);
      expected_angles.push_back(euler_of($signed(QW'(w)), $signed(QW'(x)),
                                         $signed(QW'(y)), $signed(QW'(z))));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   // check each strobed transaction and watch for a stall
   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_strobe) begin
         if (expected_angles.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            error_count++;
         end else begin
            e = expected_angles.pop_front();
            if (rsp_roll_angle !== e.roll) report_mismatch("roll", rsp_roll_angle, e.roll);
            if (rsp_pitch_angle !== e.pitch)
               report_mismatch("pitch", rsp_pitch_angle, e.pitch);
            if (rsp_yaw_angle !== e.yaw) report_mismatch("yaw", rsp_yaw_angle, e.yaw);
            if (rsp_pitch_saturated !== e.sat)
               report_mismatch("pitch_saturated", rsp_pitch_saturated, e.sat);
         end
      end
      if (rsp_strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** quaternion_to_euler_angles: FAILED **");
         $finish;
      end
   end

   // extremes, identity, gimbal lock both ways, zero operands, non-unit input
   task automatic test_directed();
      logic [QW-1:0] mx, mn;
      mx = 16'h7fff;
      mn = 16'h8000;
      send_quat(mx, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(23170, 0, 23170, 0);
      send_quat(23170, 0, -23170, 0);
      send_quat(23170, -23170, 0, 0);
      send_quat(23170, 23170, 0, 0);
      send_quat(0, mx, 0, 0);
      send_quat(0, mn, 0, 0);
      send_quat(0, 0, 0, mx);
      send_quat(0, 0, 0, mn);
      send_quat(mx, mx, mx, mx);
      send_quat(mn, mn, mn, mn);
      send_quat(mx, mn, mx, mn);
      send_quat(mn, mx, mn, mx);
      send_quat(mn, 0, mx, 0);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(16384, -16384, 16384, 16384);
      send_quat(0, 0, 23170, 23170);
      send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
      send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
      send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
      drain_results();
   endtask

   // random near-unit quaternions, plus raw bit patterns
   task automatic test_random(int count);
      int w, x, y, z, n;
      real norm;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 2) begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            w = $signed(16'($urandom)); x = $signed(16'($urandom));
            y = $signed(16'($urandom)); z = $signed(16'($urandom));
            // pull toward gimbal lock now and then
            if ($urandom_range(7) == 0) begin
               y = w; x = z;
            end
            norm = $sqrt(real'(w) * w + real'(x) * x + real'(y) * y + real'(z) * z);
            if (norm < 1.0) norm = 1.0;
            n = 32767 - $urandom_range(3);
            send_quat($rtoi(w * n / norm), $rtoi(x * n / norm),
                      $rtoi(y * n / norm), $rtoi(z * n / norm));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_gap_pct = 25;
      test_random(650);
      // hold until the pipeline has emptied
      drain_results();
      send_gap_pct = 81;
      test_random(650);
      send_gap_pct = 0;
      test_random(650);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) $display("** quaternion_to_euler_angles: PASSED **");
      else $display("** quaternion_to_euler_angles: FAILED **");
      $finish;
   end
endmodule

// ===== quaternion_to_euler_angles.f =====
rtl/core/qte_pkg.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_tb.sv
